/* rtl/coin_amt_pkg.sv */
`default_nettype none

package coin_amt_pkg;

  // parser phase within one string
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_DONE   = 2'd2,
    PH_REJECT = 2'd3
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // unit letter index, in the order the grammar requires
  typedef enum logic [1:0] {
    UNIT_GOLD   = 2'd0,
    UNIT_SILVER = 2'd1,
    UNIT_COPPER = 2'd2,
    UNIT_NONE   = 2'd3
  } unit_t;

  // one accepted input beat
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       last_char;
  } beat_t;

  // one result beat
  typedef struct packed {
    status_t     status;
    logic [31:0] copper_total;
  } result_t;

  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_G     = 8'h67;
  localparam logic [7:0]  CH_S     = 8'h73;
  localparam logic [7:0]  CH_C     = 8'h63;

  localparam logic [13:0] GOLD_WEIGHT   = 14'd10000;
  localparam logic [13:0] SILVER_WEIGHT = 14'd100;
  localparam logic [13:0] COPPER_WEIGHT = 14'd1;

  localparam logic [31:0] LIMIT32          = 32'hFFFF_FFFF;
  localparam logic [63:0] MAX_AMOUNT_RESET = 64'h0000_0000_FFFF_FFFF;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic unit_t unit_of(input logic [7:0] c);
    unit_t u;
    u = UNIT_NONE;
    if (c == CH_G) u = UNIT_GOLD;
    if (c == CH_S) u = UNIT_SILVER;
    if (c == CH_C) u = UNIT_COPPER;
    return u;
  endfunction

  function automatic logic [13:0] unit_weight(input unit_t u);
    logic [13:0] w;
    unique case (u)
      UNIT_GOLD:   w = GOLD_WEIGHT;
      UNIT_SILVER: w = SILVER_WEIGHT;
      UNIT_COPPER: w = COPPER_WEIGHT;
      default:     w = 14'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/coin_amt_in_reg.sv */
`default_nettype none

module coin_amt_in_reg
  import coin_amt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire beat_t in_beat,
  input  wire logic  consume,
  output logic       beat_valid,
  output beat_t      beat
);

  logic  valid_r, valid_nxt;
  beat_t beat_r;

  // the register is free when empty or being consumed this cycle
  assign in_ready  = !valid_r || consume;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

`default_nettype wire

/* rtl/coin_amt_core.sv */
`default_nettype none

module coin_amt_core
  import coin_amt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        beat_valid,
  input  wire beat_t       beat,
  input  wire logic        out_free,
  output logic             consume,
  output logic             res_valid,
  output result_t          res,
  output logic [63:0]      max_amount
);

  logic [63:0] max_amount_r;
  phase_t      phase_r, phase_nxt, phase_step;
  logic        seen_r, seen_nxt, seen_s;
  logic        bad_r, bad_nxt, bad_s;
  logic        pend_r, pend_nxt, pend_s;
  logic [1:0]  idx_r, idx_nxt, idx_s;
  logic [31:0] part_r, part_nxt, part_s;
  logic [31:0] total_r, total_nxt, total_s;

  logic        dig, is_space, is_unit, take_tok, end_tok, fin_bad;
  unit_t       uidx;
  logic [35:0] part_x10;
  logic [45:0] scaled;
  logic [46:0] wsum;

  // a string-ending beat needs room in the result register
  assign consume = beat_valid && (!beat.last_char || out_free);

  // character classes
  assign dig      = is_digit(beat.char_byte);
  assign is_space = (beat.char_byte == CH_SPACE);
  assign uidx     = unit_of(beat.char_byte);
  assign is_unit  = (uidx != UNIT_NONE);

  assign take_tok = beat.has_char &&
                    (((phase_r == PH_START) && dig) || ((phase_r == PH_TOKEN) && !is_space));
  assign end_tok  = beat.has_char && (phase_r == PH_TOKEN) && is_space;

  // digit accumulate and unit multiply-add
  assign part_x10 = ({4'b0, part_r} * 36'd10) + {32'b0, beat.char_byte[3:0]};
  assign scaled   = {14'b0, part_r} * {32'b0, unit_weight(uidx)};
  assign wsum     = {15'b0, total_r} + {1'b0, scaled};

  // phase next state
  always_comb begin
    phase_step = phase_r;
    if (beat.has_char) begin
      unique case (phase_r)
        PH_START: begin
          phase_step = dig ? PH_TOKEN : PH_REJECT;
        end
        PH_TOKEN: begin
          if (is_space) phase_step = PH_DONE;
        end
        PH_DONE, PH_REJECT: begin
          phase_step = phase_r;
        end
      endcase
    end
    phase_nxt = phase_r;
    if (consume) begin
      phase_nxt = beat.last_char ? PH_START : phase_step;
    end
  end

  // token datapath; any error halts it, only the letter flag keeps tracking
  always_comb begin
    seen_s  = seen_r;
    bad_s   = bad_r;
    pend_s  = pend_r;
    idx_s   = idx_r;
    part_s  = part_r;
    total_s = total_r;
    if (take_tok) begin
      if (is_unit) seen_s = 1'b1;
      if (!bad_r) begin
        priority if (dig) begin
          if (part_x10 > {4'b0, LIMIT32}) begin
            bad_s = 1'b1;
          end else begin
            part_s = part_x10[31:0];
          end
          pend_s = 1'b1;
        end else if (is_unit) begin
          priority if (!pend_r || (uidx < idx_r)) begin
            bad_s = 1'b1;
          end else if (wsum > {15'b0, LIMIT32}) begin
            bad_s = 1'b1;
          end else begin
            total_s = wsum[31:0];
            idx_s   = uidx + 2'd1;
            part_s  = 32'd0;
            pend_s  = 1'b0;
          end
        end else begin
          bad_s = 1'b1;
        end
      end
    end
    if (end_tok && pend_r) bad_s = 1'b1;
  end

  // result on the string's last beat
  assign fin_bad = bad_s || ((phase_step == PH_TOKEN) && pend_s);

  always_comb begin
    res.status       = ST_OK;
    res.copper_total = 32'd0;
    priority if ((phase_step == PH_START) || (phase_step == PH_REJECT) || !seen_s) begin
      res.status = ST_NONE;
    end else if (fin_bad || ({32'b0, total_s} > max_amount_r)) begin
      res.status = ST_INVALID;
    end else begin
      res.copper_total = total_s;
    end
  end

  assign res_valid = consume && beat.last_char;

  // register next values, cleared after a string ends
  always_comb begin
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    pend_nxt  = pend_r;
    idx_nxt   = idx_r;
    part_nxt  = part_r;
    total_nxt = total_r;
    if (consume) begin
      if (beat.last_char) begin
        seen_nxt  = 1'b0;
        bad_nxt   = 1'b0;
        pend_nxt  = 1'b0;
        idx_nxt   = 2'd0;
        part_nxt  = 32'd0;
        total_nxt = 32'd0;
      end else begin
        seen_nxt  = seen_s;
        bad_nxt   = bad_s;
        pend_nxt  = pend_s;
        idx_nxt   = idx_s;
        part_nxt  = part_s;
        total_nxt = total_s;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
      pend_r  <= 1'b0;
      idx_r   <= 2'd0;
      part_r  <= 32'd0;
      total_r <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
      part_r  <= part_nxt;
      total_r <= total_nxt;
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_amount_r <= MAX_AMOUNT_RESET;
    end else if (cfg_wr_en) begin
      max_amount_r <= cfg_wr_data;
    end
  end

  assign max_amount = max_amount_r;

endmodule

`default_nettype wire

/* rtl/coin_amt_out_reg.sv */
`default_nettype none

module coin_amt_out_reg
  import coin_amt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         out_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // free when empty or the waiting beat leaves this cycle
  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = out_free ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

/* rtl/coin_amount_token_parser.sv */
// The string's last input beat passes the input register, then the result register, before
// out_valid rises. Throughput: one character beat per cycle, but a string's last beat
// stalls in the input register while the result register is full. The rate is set by the
// parser state loop through one 32x14 constant multiply-add and its limit compare.
// Reset (synchronous, rst_n low): parser at token start, no beats held, limit = 2^32-1.
`default_nettype none

module coin_amount_token_parser
  import coin_amt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_has_char,
  input  wire logic        in_last_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_copper_total
);

  beat_t       in_beat, beat;
  logic        beat_valid, consume, res_valid, out_free;
  result_t     res, out_res;
  logic [63:0] max_amount;

  assign in_beat.char_byte = in_char_byte;
  assign in_beat.has_char  = in_has_char;
  assign in_beat.last_char = in_last_char;

  coin_amt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .consume    (consume),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  coin_amt_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat_valid  (beat_valid),
    .beat        (beat),
    .out_free    (out_free),
    .consume     (consume),
    .res_valid   (res_valid),
    .res         (res),
    .max_amount  (max_amount)
  );

  coin_amt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_copper_total = out_res.copper_total;

  // a non-ok result carries no amount
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_copper_total == 32'd0))
    else $error("non-ok result with nonzero amount");

  // an ok amount never exceeds the limit register
  a_ok_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |-> ({32'b0, out_copper_total} <= max_amount))
    else $error("ok amount above limit");

  // a held input beat is not overwritten before the parser takes it
  a_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid && !consume) |=> (beat_valid && $stable(beat)))
    else $error("input beat lost while stalled");

  // a result is only produced when the result register can take it
  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result produced while result register full");

endmodule

`default_nettype wire

/* sim/coin_amount_token_parser_checker.sv */
module coin_amount_token_parser_checker
  import coin_amt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_has_char,
  input  wire logic        in_last_char,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [31:0] out_copper_total,
  output int               error_count,
  output int               results_due,
  output int               results_checked
);

  localparam logic [63:0] ALL_ONES = '1;

  // shadow of the limit register and of the token parser
  logic [63:0] limit_copy;
  phase_t      tok_phase;
  logic        letter_seen;
  logic        syntax_bad;
  logic        range_bad;
  logic        digits_open;
  unit_t       next_unit;
  logic [63:0] part_acc;
  logic [63:0] total_acc;

  // amounts still owed by the block, oldest first
  result_t     owed_results [$];
  int          errors = 0;
  int          checked = 0;

  task automatic clear_token();
    tok_phase   = PH_START;
    letter_seen = 1'b0;
    syntax_bad  = 1'b0;
    range_bad   = 1'b0;
    digits_open = 1'b0;
    next_unit   = UNIT_GOLD;
    part_acc    = '0;
    total_acc   = '0;
  endtask

  // one character inside the token: digit accumulate or unit letter fold-in
  task automatic absorb_token_char(input logic [7:0] c);
    logic        is_letter;
    logic [63:0] digit;
    logic [63:0] weight;
    unit_t       hit;
    is_letter = (c == CH_G) || (c == CH_S) || (c == CH_C);
    if (is_letter) letter_seen = 1'b1;
    if (syntax_bad || range_bad) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = 64'(c - CH_ZERO);
      if (part_acc > (ALL_ONES - digit) / 64'd10) range_bad = 1'b1;
      else part_acc = part_acc * 64'd10 + digit;
      digits_open = 1'b1;
    end else if (is_letter) begin
      if (!digits_open) begin
        syntax_bad = 1'b1;
        return;
      end
      hit = (c == CH_G) ? UNIT_GOLD : (c == CH_S) ? UNIT_SILVER : UNIT_COPPER;
      // letters must come in gold, silver, copper order, each once
      if (hit < next_unit) begin
        syntax_bad = 1'b1;
        return;
      end
      case (hit)
        UNIT_GOLD:   weight = 64'(GOLD_WEIGHT);
        UNIT_SILVER: weight = 64'(SILVER_WEIGHT);
        default:     weight = 64'(COPPER_WEIGHT);
      endcase
      if (part_acc > (ALL_ONES - total_acc) / weight) begin
        range_bad = 1'b1;
        return;
      end
      total_acc   = total_acc + part_acc * weight;
      next_unit   = unit_t'(hit + 1);
      part_acc    = '0;
      digits_open = 1'b0;
    end else begin
      syntax_bad = 1'b1;
    end
  endtask

  // one input beat; queues the expected amount on the string's last beat
  task automatic parse_coin_beat(input logic [7:0] c, input logic has_ch,
                                 input logic is_last);
    result_t want;
    if (has_ch) begin
      case (tok_phase)
        PH_START: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            tok_phase = PH_TOKEN;
            absorb_token_char(c);
          end else begin
            tok_phase = PH_REJECT;
          end
        end
        PH_TOKEN: begin
          if (c == CH_SPACE) begin
            if (digits_open) syntax_bad = 1'b1;
            tok_phase = PH_DONE;
          end else begin
            absorb_token_char(c);
          end
        end
        default: ;
      endcase
    end
    if (!is_last) return;
    if (tok_phase == PH_TOKEN && digits_open) syntax_bad = 1'b1;
    want.copper_total = '0;
    if (tok_phase == PH_START || tok_phase == PH_REJECT || !letter_seen)
      want.status = ST_NONE;
    else if (syntax_bad || range_bad)
      want.status = ST_INVALID;
    else if (total_acc > limit_copy || total_acc > 64'(LIMIT32))
      want.status = ST_INVALID;
    else begin
      want.status       = ST_OK;
      want.copper_total = total_acc[31:0];
    end
    owed_results.push_back(want);
    clear_token();
  endtask

  task automatic check_result();
    result_t want;
    if (owed_results.size() == 0) begin
      $error("result beat with nothing owed: out_status %0d, out_copper_total %0d",
             out_status, out_copper_total);
      errors++;
    end else begin
      want = owed_results.pop_front();
      checked++;
      if (out_status !== want.status) begin
        $error("out_status: expected %0d, actual %0d", want.status, out_status);
        errors++;
      end
      if (out_copper_total !== want.copper_total) begin
        $error("out_copper_total: expected %0d, actual %0d",
               want.copper_total, out_copper_total);
        errors++;
      end
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      limit_copy = MAX_AMOUNT_RESET;
      clear_token();
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_wr_en) limit_copy = cfg_wr_data;
      if (in_valid && in_ready) parse_coin_beat(in_char_byte, in_has_char, in_last_char);
    end
    error_count     <= errors;
    results_due     <= owed_results.size();
    results_checked <= checked;
  end

endmodule

/* sim/coin_amount_token_parser_tb.sv */
module coin_amount_token_parser_tb;
  import coin_amt_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 4;
  localparam int          PHASE_BEATS = 50;
  localparam int          NUM_PHASES  = 7;
  localparam logic [63:0] ALL_ONES    = '1;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_char_byte = '0;
  logic        in_has_char = 1'b0;
  logic        in_last_char = 1'b0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [1:0]  out_status;
  wire  [31:0] out_copper_total;

  int          error_count;
  int          results_due;
  int          results_checked;
  int          send_idle_pct = 13;
  int          recv_idle_pct = 55;
  int          beats_sent = 0;
  int          strings_sent = 0;
  int          limits_used = 0;
  logic [63:0] cur_limit = MAX_AMOUNT_RESET;
  logic [7:0]  text_buf [$];

  coin_amount_token_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_has_char      (in_has_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_copper_total (out_copper_total)
  );

  coin_amount_token_parser_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_has_char      (in_has_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_copper_total (out_copper_total),
    .error_count      (error_count),
    .results_due      (results_due),
    .results_checked  (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // end the run if no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("coin_amount_token_parser_tb failed");
    $finish;
  end

  // one input beat, with random gaps ahead of it
  task automatic send_beat(input logic [7:0] c, input logic has_ch, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_has_char  <= has_ch;
    in_last_char <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (has_ch || is_last) beats_sent++;
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b1, i == s.len() - 1);
  endtask

  // send text_buf as one string, with stray empty beats mixed in
  task automatic send_text();
    bit empty_end;
    empty_end = (text_buf.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (text_buf[i]) begin
      if ($urandom_range(0, 11) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(text_buf[i], 1'b1, !empty_end && (i == text_buf.size() - 1));
    end
    if (empty_end) send_beat(8'($urandom), 1'b0, 1'b1);
    strings_sent++;
  endtask

  // stop sending until every owed amount is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [63:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_limit   = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limits_used++;
  endtask

  task automatic append_number(input logic [63:0] v, input int pad);
    logic [7:0] digs [20];
    int         n;
    n = 0;
    repeat (pad) text_buf.push_back(CH_ZERO);
    do begin
      digs[n] = CH_ZERO + 8'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 0);
    for (int i = n - 1; i >= 0; i--) text_buf.push_back(digs[i]);
  endtask

  // part values around the interesting boundaries for one unit
  function automatic logic [63:0] pick_part(input unit_t u);
    logic [63:0] w;
    logic [63:0] v;
    case (u)
      UNIT_GOLD:   w = 64'(GOLD_WEIGHT);
      UNIT_SILVER: w = 64'(SILVER_WEIGHT);
      default:     w = 64'(COPPER_WEIGHT);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = 64'($urandom_range(0, 999));
      6:       v = 64'(LIMIT32) / w + 64'($urandom_range(0, 6)) - 64'd3;
      7:       v = cur_limit / w + 64'($urandom_range(0, 2)) - 64'd1;
      8:       v = {$urandom, $urandom};
      default: v = ALL_ONES - 64'($urandom_range(0, 20));
    endcase
    return v;
  endfunction

  task automatic append_part(input unit_t u);
    if ($urandom_range(0, 14) == 0) begin
      // right at the 64-bit edge of one part
      append_number(64'd1844674407370955161, 0);
      text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      append_number(pick_part(u), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    end
    case (u)
      UNIT_GOLD:   text_buf.push_back(CH_G);
      UNIT_SILVER: text_buf.push_back(CH_S);
      default:     text_buf.push_back(CH_C);
    endcase
  endtask

  // an amount like 12g3s40c, optionally damaged, optionally with trailing text
  task automatic build_amount(input bit broken);
    bit    any;
    unit_t u;
    int    pos;
    text_buf.delete();
    any = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 1) == 1 || (k == 2 && !any)) begin
        u = unit_t'(k);
        if (broken && $urandom_range(0, 2) == 0) u = unit_t'($urandom_range(0, 2));
        append_part(u);
        any = 1'b1;
      end
    end
    if (broken) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: text_buf.insert(pos, 8'($urandom_range(0, 255)));
        1: text_buf[pos] = 8'($urandom_range(0, 255));
        2: append_number(64'($urandom_range(0, 99)), 0);
        default: text_buf.insert(pos, ($urandom_range(0, 1) == 1) ? CH_S : CH_G);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      text_buf.push_back(CH_SPACE);
      repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_noise();
    text_buf.delete();
    repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int          start;
    int          roll;
    logic [63:0] lim;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings under the reset limit
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat("1", 1'b1, 1'b0);
    send_beat("g", 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_word("2s3c");
    send_word("c");
    send_word("12");
    send_word("1s2g");
    send_word("7c x");
    send_beat(CH_ZERO, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(CH_C, 1'b1, 1'b1);
    send_beat(CH_ZERO, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    strings_sent += 8;

    // random strings, one limit setting and idle pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      send_idle_pct = (p < 3) ? 13 : (p < 5) ? 55 : 0;
      recv_idle_pct = (p < 3) ? 55 : (p < 5) ? 13 : 0;
      case (p)
        0:       lim = MAX_AMOUNT_RESET;
        1:       lim = '0;
        2:       lim = ALL_ONES;
        3:       lim = 64'd10203;
        4:       lim = {$urandom, $urandom};
        5:       lim = 64'h1_0000_0000;
        default: lim = 64'($urandom);
      endcase
      write_limit(lim);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) build_amount(1'b0);
        else if (roll < 85) build_amount(1'b1);
        else build_noise();
        send_text();
      end
    end
    drain();

    $display("covered %0d strings in %0d beats, %0d results compared",
             strings_sent, beats_sent, results_checked);
    $display("limit written %0d times from zero to all ones, under three idle patterns",
             limits_used);
    if (error_count == 0 && results_due == 0) begin
      $display("coin_amount_token_parser_tb passed");
    end else begin
      $display("coin_amount_token_parser_tb failed");
    end
    $finish;
  end

endmodule
